// ----- design/bls_pkg.sv -----
// bls_pkg: shared types and constants for the Bresenham line stepper.
// Configuration register indexes, request kinds and fixed field widths.
// No dependencies.
`default_nettype none

package bls_pkg;

    localparam int WIN_W      = 13;
    localparam int PITCH_W    = 16;
    localparam int BPP_W      = 4;
    localparam int COLOR_W    = 32;
    localparam int OFFSET_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_WIDTH     = 3'd0,
        CFG_WIN_HEIGHT    = 3'd1,
        CFG_ROW_PITCH     = 3'd2,
        CFG_BYTES_PER_PIX = 3'd3,
        CFG_DEFAULT_COLOR = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_type_t;

    localparam logic [WIN_W-1:0]   WIN_WIDTH_RST     = 13'd1920;
    localparam logic [WIN_W-1:0]   WIN_HEIGHT_RST    = 13'd1080;
    localparam logic [PITCH_W-1:0] ROW_PITCH_RST     = 16'd7680;
    localparam logic [BPP_W-1:0]   BYTES_PER_PIX_RST = 4'd4;
    localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = 32'h00FF_FFFF;

endpackage

`default_nettype wire

// ----- design/bresenham_line_stepper_top.sv -----
// bresenham_line_stepper_top: Bresenham line generator, one pixel item per input item.
// Depends on bls_pkg.
`default_nettype none

// One result item per input item, one item per cycle unless m_tready stalls the output;
// each result is registered in stage 1, stage 2 and the output register. The line state
// (position, deltas, error term) is updated at accept; a second register stage forms the
// window test and the two offset products, and the output register holds the summed byte
// offset. Each stage advances independently, so input is taken while a finished result
// waits as long as an earlier stage is empty. A start item (tuser = 0) loads the endpoints
// and emits the start point; a step item (tuser = 1) emits the next pixel, or a zero item
// with m_tuser = 0 when no line is active. Write configuration only while no item is in
// flight: the window and offset registers are read in the second stage.
module bresenham_line_stepper_top #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bls_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // start_x, start_y, end_x, end_y, line_color, use_default, zero pad
    input  wire logic [((4*COORD_BITS+33+7)/8)*8-1:0] s_tdata,
    // req_type
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // pixel_x, pixel_y, in_window, byte_offset, pixel_color, zero pad
    output logic [((2*COORD_BITS+65+7)/8)*8-1:0] m_tdata,
    // pixel_valid
    output logic                                 m_tuser,
    // last_pixel
    output logic                                 m_tlast
);
    import bls_pkg::*;

    localparam int CW     = COORD_BITS;
    localparam int DEL_W  = CW + 1;
    localparam int ERR_W  = CW + 3;
    localparam int TW_W   = CW + 4;
    localparam int OUT_W  = ((2*CW+65+7)/8)*8;
    localparam int PAD_W  = OUT_W - (2*CW+65);
    localparam int PY_W   = CW - 1 + PITCH_W;
    localparam int PX_W   = CW - 1 + BPP_W;

    // configuration
    logic [WIN_W-1:0]   win_width_reg;
    logic [WIN_W-1:0]   win_height_reg;
    logic [PITCH_W-1:0] row_pitch_reg;
    logic [BPP_W-1:0]   bpp_reg;
    logic [COLOR_W-1:0] default_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_width_reg     <= WIN_WIDTH_RST;
            win_height_reg    <= WIN_HEIGHT_RST;
            row_pitch_reg     <= ROW_PITCH_RST;
            bpp_reg           <= BYTES_PER_PIX_RST;
            default_color_reg <= DEFAULT_COLOR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WIN_WIDTH:     win_width_reg     <= cfg_wdata[WIN_W-1:0];
                CFG_WIN_HEIGHT:    win_height_reg    <= cfg_wdata[WIN_W-1:0];
                CFG_ROW_PITCH:     row_pitch_reg     <= cfg_wdata[PITCH_W-1:0];
                CFG_BYTES_PER_PIX: bpp_reg           <= cfg_wdata[BPP_W-1:0];
                CFG_DEFAULT_COLOR: default_color_reg <= cfg_wdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    logic st1_valid_reg, st2_valid_reg, m_valid_reg;
    logic out_free, st2_free, st1_free, s_accept;

    assign out_free = !m_valid_reg || m_tready;
    assign st2_free = !st2_valid_reg || out_free;
    assign st1_free = !st1_valid_reg || st2_free;
    assign s_tready = st1_free;
    assign s_accept = s_tvalid && st1_free;

    // input unpack
    logic signed [CW-1:0] in_sx, in_sy, in_ex, in_ey;
    logic [COLOR_W-1:0]   in_color;
    logic                 in_use_default;

    assign in_sx          = s_tdata[CW-1:0];
    assign in_sy          = s_tdata[2*CW-1:CW];
    assign in_ex          = s_tdata[3*CW-1:2*CW];
    assign in_ey          = s_tdata[4*CW-1:3*CW];
    assign in_color       = s_tdata[4*CW+31:4*CW];
    assign in_use_default = s_tdata[4*CW+32];

    // line state
    logic signed [CW-1:0]    cur_x_reg, cur_y_reg, tgt_x_reg, tgt_y_reg;
    logic [DEL_W-1:0]        dx_reg, dy_reg;
    logic                    step_x_neg_reg, step_y_neg_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [COLOR_W-1:0]      color_reg;
    logic                    line_active_reg;

    logic signed [CW-1:0]    cur_x_next, cur_y_next, tgt_x_next, tgt_y_next;
    logic [DEL_W-1:0]        dx_next, dy_next;
    logic                    step_x_neg_next, step_y_neg_next;
    logic signed [ERR_W-1:0] err_next;
    logic [COLOR_W-1:0]      color_next;
    logic                    line_active_next;
    logic                    emit_pix, emit_last;

    // start path
    logic [DEL_W-1:0] diff_x, diff_y, dx_abs, dy_abs;
    assign diff_x = {in_ex[CW-1], in_ex} - {in_sx[CW-1], in_sx};
    assign diff_y = {in_ey[CW-1], in_ey} - {in_sy[CW-1], in_sy};
    assign dx_abs = diff_x[DEL_W-1] ? -diff_x : diff_x;
    assign dy_abs = diff_y[DEL_W-1] ? -diff_y : diff_y;

    // step path
    logic signed [TW_W-1:0] twice, neg_dy, dx_ext;
    logic                   mv_x, mv_y;
    logic [CW-1:0]          x_inc, y_inc;
    logic signed [CW-1:0]   x_step, y_step;
    logic [ERR_W-1:0]       err_sub, err_add;

    assign twice  = {err_reg, 1'b0};
    assign neg_dy = -signed'({3'b000, dy_reg});
    assign dx_ext = {3'b000, dx_reg};
    assign mv_x   = twice > neg_dy;
    assign mv_y   = twice < dx_ext;
    assign x_inc  = mv_x ? (step_x_neg_reg ? {CW{1'b1}} : {{(CW-1){1'b0}}, 1'b1})
                         : '0;
    assign y_inc  = mv_y ? (step_y_neg_reg ? {CW{1'b1}} : {{(CW-1){1'b0}}, 1'b1})
                         : '0;
    assign x_step = cur_x_reg + x_inc;
    assign y_step = cur_y_reg + y_inc;
    assign err_sub = mv_x ? {2'b00, dy_reg} : '0;
    assign err_add = mv_y ? {2'b00, dx_reg} : '0;

    always_comb begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        tgt_x_next       = tgt_x_reg;
        tgt_y_next       = tgt_y_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        step_x_neg_next  = step_x_neg_reg;
        step_y_neg_next  = step_y_neg_reg;
        err_next         = err_reg;
        color_next       = color_reg;
        line_active_next = line_active_reg;
        emit_pix         = 1'b0;
        emit_last        = 1'b0;
        if (s_tuser == REQ_START) begin
            cur_x_next       = in_sx;
            cur_y_next       = in_sy;
            tgt_x_next       = in_ex;
            tgt_y_next       = in_ey;
            dx_next          = dx_abs;
            dy_next          = dy_abs;
            step_x_neg_next  = !(in_sx < in_ex);
            step_y_neg_next  = !(in_sy < in_ey);
            err_next         = {2'b00, dx_abs} - {2'b00, dy_abs};
            color_next       = in_use_default ? default_color_reg : in_color;
            emit_pix         = 1'b1;
            emit_last        = (in_sx == in_ex) && (in_sy == in_ey);
            line_active_next = !emit_last;
        end else if (line_active_reg) begin
            cur_x_next       = x_step;
            cur_y_next       = y_step;
            err_next         = err_reg - err_sub + err_add;
            emit_pix         = 1'b1;
            emit_last        = (x_step == tgt_x_reg) && (y_step == tgt_y_reg);
            line_active_next = !emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
        end else if (s_accept) begin
            line_active_reg <= line_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            tgt_x_reg      <= tgt_x_next;
            tgt_y_reg      <= tgt_y_next;
            dx_reg         <= dx_next;
            dy_reg         <= dy_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
            err_reg        <= err_next;
            color_reg      <= color_next;
        end
    end

    // stage 1: pixel to emit
    logic [CW-1:0]      st1_x_reg, st1_y_reg;
    logic [COLOR_W-1:0] st1_color_reg;
    logic               st1_pix_reg, st1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (st1_free) begin
            st1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_pix_reg   <= emit_pix;
            st1_last_reg  <= emit_last;
            st1_x_reg     <= emit_pix ? cur_x_next : '0;
            st1_y_reg     <= emit_pix ? cur_y_next : '0;
            st1_color_reg <= emit_pix ? color_next : '0;
        end
    end

    // stage 2: window test and offset products
    logic [CW-2:0]   x_mag, y_mag;
    logic            pix_in_win;
    logic [PY_W-1:0] prod_y;
    logic [PX_W-1:0] prod_x;

    assign x_mag  = st1_x_reg[CW-2:0];
    assign y_mag  = st1_y_reg[CW-2:0];
    assign pix_in_win = st1_pix_reg && !st1_x_reg[CW-1] && !st1_y_reg[CW-1] &&
                        (32'(x_mag) < 32'(win_width_reg)) &&
                        (32'(y_mag) < 32'(win_height_reg));
    assign prod_y = PY_W'(y_mag) * PY_W'(row_pitch_reg);
    assign prod_x = PX_W'(x_mag) * PX_W'(bpp_reg);

    logic [CW-1:0]       st2_x_reg, st2_y_reg;
    logic [COLOR_W-1:0]  st2_color_reg;
    logic                st2_pix_reg, st2_last_reg, st2_inside_reg;
    logic [OFFSET_W-1:0] st2_prod_y_reg, st2_prod_x_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (st2_free) begin
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st2_free) begin
            st2_x_reg      <= st1_x_reg;
            st2_y_reg      <= st1_y_reg;
            st2_color_reg  <= st1_color_reg;
            st2_pix_reg    <= st1_pix_reg;
            st2_last_reg   <= st1_last_reg;
            st2_inside_reg <= pix_in_win;
            st2_prod_y_reg <= OFFSET_W'(prod_y);
            st2_prod_x_reg <= OFFSET_W'(prod_x);
        end
    end

    // output register
    logic [CW-1:0]       out_x_reg, out_y_reg;
    logic [COLOR_W-1:0]  out_color_reg;
    logic                out_pix_reg, out_last_reg, out_inside_reg;
    logic [OFFSET_W-1:0] out_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_x_reg      <= st2_x_reg;
            out_y_reg      <= st2_y_reg;
            out_color_reg  <= st2_color_reg;
            out_pix_reg    <= st2_pix_reg;
            out_last_reg   <= st2_last_reg;
            out_inside_reg <= st2_inside_reg;
            out_offset_reg <= st2_inside_reg ? st2_prod_y_reg + st2_prod_x_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_pix_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_color_reg, out_offset_reg, out_inside_reg,
                       out_y_reg, out_x_reg};

`ifndef SYNTHESIS
    // an empty result carries nothing
    a_null_item_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata == '0) && !m_tlast)
        else $error("null item with nonzero payload");

    // a step with no active line must yield a null item
    a_idle_step_null: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tuser == REQ_STEP) && !line_active_reg |=> !st1_pix_reg)
        else $error("pixel emitted with no active line");

    // a pending end-point pixel means the line is closed
    a_last_closes_line: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && st1_last_reg |-> !line_active_reg)
        else $error("line still active after end point");

    // a pixel outside the window has no byte offset
    a_clip_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_inside_reg |-> out_offset_reg == '0)
        else $error("clipped pixel with nonzero offset");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_bresenham_line_stepper_top.sv -----
// Self-checking testbench for bresenham_line_stepper_top: a directed table, then random
// lines under several register settings, checked against an in-bench pixel predictor.
// Depends on bls_pkg and the DUT sources only.
`default_nettype none

module tb_bresenham_line_stepper_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;

    localparam int CB     = 16;
    localparam int S_W    = ((4*CB+33+7)/8)*8;
    localparam int M_W    = ((2*CB+65+7)/8)*8;
    localparam int DRAIN  = 10;

    typedef struct packed {
        req_type_t           kind;
        logic [CB-1:0]       sx;
        logic [CB-1:0]       sy;
        logic [CB-1:0]       ex;
        logic [CB-1:0]       ey;
        logic [COLOR_W-1:0]  color;
        logic                use_def;
    } line_req_t;

    typedef struct packed {
        logic                valid;
        logic [CB-1:0]       x;
        logic [CB-1:0]       y;
        logic                in_win;
        logic [OFFSET_W-1:0] offset;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } pixel_t;

    typedef struct {
        line_req_t item;
        bit        fixed;
        pixel_t    want;
    } stim_row_t;

    localparam pixel_t NO_PIXEL = '0;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_W-1:0]        m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    bresenham_line_stepper_top #(.COORD_BITS(CB)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // predictor copy of the registers and the line state
    longint cfg_win_w = 1920, cfg_win_h = 1080, cfg_pitch = 7680, cfg_bpp = 4;
    logic [COLOR_W-1:0] cfg_color = 32'h00FF_FFFF;
    longint pen_x, pen_y, goal_x, goal_y, span_x, span_y, err_acc;
    bit walk_x_neg, walk_y_neg, line_live;
    logic [COLOR_W-1:0] line_rgb;
    initial begin
        pen_x = 0; pen_y = 0; goal_x = 0; goal_y = 0;
        span_x = 0; span_y = 0; err_acc = 0;
        walk_x_neg = 0; walk_y_neg = 0; line_live = 0; line_rgb = '0;
    end

    pixel_t pending_pixels[$];
    int     mismatch_count = 0;
    int     items_sent = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;

    function automatic pixel_t pixel_here(bit last);
        pixel_t p;
        longint lin;
        p.valid  = 1'b1;
        p.x      = pen_x[CB-1:0];
        p.y      = pen_y[CB-1:0];
        p.in_win = pen_x >= 0 && pen_x < cfg_win_w && pen_y >= 0 && pen_y < cfg_win_h;
        lin      = pen_y * cfg_pitch + pen_x * cfg_bpp;
        p.offset = p.in_win ? lin[OFFSET_W-1:0] : '0;
        p.color  = line_rgb;
        p.last   = last;
        return p;
    endfunction

    function automatic pixel_t predict_pixel(line_req_t r);
        longint twice;
        bit done;
        if (r.kind == REQ_START) begin
            pen_x  = longint'($signed(r.sx));
            pen_y  = longint'($signed(r.sy));
            goal_x = longint'($signed(r.ex));
            goal_y = longint'($signed(r.ey));
            span_x = goal_x - pen_x;
            if (span_x < 0) span_x = -span_x;
            span_y = goal_y - pen_y;
            if (span_y < 0) span_y = -span_y;
            walk_x_neg = !(pen_x < goal_x);
            walk_y_neg = !(pen_y < goal_y);
            err_acc  = span_x - span_y;
            line_rgb = r.use_def ? cfg_color : r.color;
            done = (pen_x == goal_x && pen_y == goal_y);
            line_live = !done;
            return pixel_here(done);
        end
        if (!line_live)
            return NO_PIXEL;
        twice = 2 * err_acc;
        if (twice > -span_y) begin
            err_acc -= span_y;
            pen_x += walk_x_neg ? -1 : 1;
        end
        if (twice < span_x) begin
            err_acc += span_x;
            pen_y += walk_y_neg ? -1 : 1;
        end
        done = (pen_x == goal_x && pen_y == goal_y);
        if (done)
            line_live = 0;
        return pixel_here(done);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // result side: random stalls, compare each accepted item with the oldest prediction
    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.valid  = m_tuser;
            got.x      = m_tdata[15:0];
            got.y      = m_tdata[31:16];
            got.in_win = m_tdata[32];
            got.offset = m_tdata[64:33];
            got.color  = m_tdata[96:65];
            got.last   = m_tlast;
            if (pending_pixels.size() == 0) begin
                report_mismatch("item with no prediction", {got.y, got.x}, 0);
            end else begin
                want = pending_pixels.pop_front();
                if (got.valid !== want.valid)
                    report_mismatch("pixel_valid", 32'(got.valid), 32'(want.valid));
                if (got.x !== want.x)
                    report_mismatch("pixel_x", 32'(got.x), 32'(want.x));
                if (got.y !== want.y)
                    report_mismatch("pixel_y", 32'(got.y), 32'(want.y));
                if (got.in_win !== want.in_win)
                    report_mismatch("in_window", 32'(got.in_win), 32'(want.in_win));
                if (got.offset !== want.offset)
                    report_mismatch("byte_offset", got.offset, want.offset);
                if (got.color !== want.color)
                    report_mismatch("pixel_color", got.color, want.color);
                if (got.last !== want.last)
                    report_mismatch("last_pixel", 32'(got.last), 32'(want.last));
                if (m_tdata[M_W-1:97] !== '0)
                    report_mismatch("tdata pad", 32'(m_tdata[M_W-1:97]), 0);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(line_req_t r, bit fixed, pixel_t want);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {{(S_W-97){1'b0}}, r.use_def, r.color, r.ey, r.ex, r.sy, r.sx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (fixed) begin
            void'(predict_pixel(r));
            pending_pixels.push_back(want);
        end else begin
            pending_pixels.push_back(predict_pixel(r));
        end
        items_sent++;
    endtask

    // block must be idle: drain all results, then let the pipeline settle
    task automatic write_registers(logic [CFG_DATA_W-1:0] vals[5]);
        cfg_reg_t idx;
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        for (int i = 0; i < 5; i++) begin
            idx = cfg_reg_t'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= vals[i];
            @(posedge aclk);
            case (idx)
                CFG_WIN_WIDTH:     cfg_win_w = longint'(vals[i][WIN_W-1:0]);
                CFG_WIN_HEIGHT:    cfg_win_h = longint'(vals[i][WIN_W-1:0]);
                CFG_ROW_PITCH:     cfg_pitch = longint'(vals[i][PITCH_W-1:0]);
                CFG_BYTES_PER_PIX: cfg_bpp   = longint'(vals[i][BPP_W-1:0]);
                CFG_DEFAULT_COLOR: cfg_color = vals[i][COLOR_W-1:0];
                default: ;
            endcase
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CB-1:0] near(longint base, int spread);
        longint v;
        v = base + longint'($urandom_range(2*spread)) - spread;
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return v[CB-1:0];
    endfunction

    function automatic logic [CB-1:0] corner();
        return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endfunction

    function automatic line_req_t junk_req(req_type_t k);
        line_req_t r;
        r.kind    = k;
        r.sx      = CB'($urandom);
        r.sy      = CB'($urandom);
        r.ex      = CB'($urandom);
        r.ey      = CB'($urandom);
        r.color   = $urandom;
        r.use_def = 1'($urandom_range(1));
        return r;
    endfunction

    // mostly whole lines walked to their end, some cut short, some noise
    task automatic run_random(int count);
        line_req_t r;
        int stop_at, pick, steps;
        longint len_x, len_y;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                send_item(junk_req(req_type_t'($urandom_range(1))), 0, NO_PIXEL);
            end else begin
                r = junk_req(REQ_START);
                case ($urandom_range(9))
                    0, 1, 2, 3: begin r.sx = near(0, 12); r.sy = near(0, 12); end
                    4, 5, 6: begin
                        r.sx = near(cfg_win_w, 12);
                        r.sy = near(cfg_win_h, 12);
                    end
                    7, 8: ;
                    default: begin r.sx = corner(); r.sy = corner(); end
                endcase
                if ($urandom_range(99) < 85) begin
                    r.ex = near(longint'($signed(r.sx)), 20);
                    r.ey = near(longint'($signed(r.sy)), 20);
                end
                send_item(r, 0, NO_PIXEL);
                len_x = longint'($signed(r.ex)) - longint'($signed(r.sx));
                len_y = longint'($signed(r.ey)) - longint'($signed(r.sy));
                if (len_x < 0) len_x = -len_x;
                if (len_y < 0) len_y = -len_y;
                steps = (len_x > len_y) ? int'(len_x) : int'(len_y);
                if (steps > 40) steps = 40;
                if (pick < 20)
                    steps = $urandom_range(steps);
                else
                    steps += $urandom_range(2);
                repeat (steps) send_item(junk_req(REQ_STEP), 0, NO_PIXEL);
            end
        end
    endtask

    function automatic stim_row_t row(req_type_t k, int sx, int sy, int ex, int ey,
                                      logic [31:0] color, bit ud, bit fixed, pixel_t want);
        stim_row_t t;
        t.item.kind    = k;
        t.item.sx      = sx[CB-1:0];
        t.item.sy      = sy[CB-1:0];
        t.item.ex      = ex[CB-1:0];
        t.item.ey      = ey[CB-1:0];
        t.item.color   = color;
        t.item.use_def = ud;
        t.fixed        = fixed;
        t.want         = want;
        return t;
    endfunction

    function automatic pixel_t pix(logic [CB-1:0] x, logic [CB-1:0] y, bit in_win,
                                   logic [31:0] offset, logic [31:0] color, bit last);
        pixel_t p;
        p.valid  = 1'b1;
        p.x      = x;
        p.y      = y;
        p.in_win = in_win;
        p.offset = offset;
        p.color  = color;
        p.last   = last;
        return p;
    endfunction

    initial begin
        stim_row_t directed[$];
        logic [CFG_DATA_W-1:0] vals[5];

        directed.push_back(row(REQ_STEP, 0, 0, 0, 0, 0, 0, 1, NO_PIXEL));
        directed.push_back(row(REQ_START, 0, 0, 0, 0, 32'h1234_5678, 0, 1,
                               pix(0, 0, 1, 0, 32'h1234_5678, 1)));
        directed.push_back(row(REQ_STEP, 0, 0, 0, 0, 0, 0, 1, NO_PIXEL));
        directed.push_back(row(REQ_START, 0, 0, 3, 1, 32'hA5A5_A5A5, 0, 0, NO_PIXEL));
        repeat (3) directed.push_back(row(REQ_STEP, -1, -1, -1, -1, '1, 1, 0, NO_PIXEL));
        directed.push_back(row(REQ_STEP, 0, 0, 0, 0, 0, 0, 1, NO_PIXEL));
        directed.push_back(row(REQ_START, -32768, -32768, 32767, 32767, 32'h0, 1, 1,
                               pix(16'h8000, 16'h8000, 0, 0, 32'h00FF_FFFF, 0)));
        repeat (2) directed.push_back(row(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, NO_PIXEL));
        directed.push_back(row(REQ_START, 32767, 32767, 32767, 32767, 32'hFFFF_FFFF, 0, 1,
                               pix(16'h7FFF, 16'h7FFF, 0, 0, 32'hFFFF_FFFF, 1)));
        directed.push_back(row(REQ_START, 1919, 1079, 1920, 1080, 32'h0F0F_0F0F, 0, 0,
                               NO_PIXEL));
        repeat (2) directed.push_back(row(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, NO_PIXEL));
        directed.push_back(row(REQ_START, 5, 5, 0, 0, 32'h0000_0001, 1, 0, NO_PIXEL));
        repeat (2) directed.push_back(row(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, NO_PIXEL));
        // restart while the previous line is still in progress
        directed.push_back(row(REQ_START, 2, -2, -2, 2, 32'h8000_0000, 0, 0, NO_PIXEL));
        repeat (2) directed.push_back(row(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, NO_PIXEL));
        directed.push_back(row(REQ_START, -1, -1, 1, 1, 32'h5A5A_5A5A, 0, 0, NO_PIXEL));
        directed.push_back(row(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, NO_PIXEL));
        directed.push_back(row(REQ_START, 0, 1079, 0, 1081, 32'h00C0_FFEE, 0, 0, NO_PIXEL));
        repeat (2) directed.push_back(row(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, NO_PIXEL));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 34;
        recv_idle_pct = 64;
        foreach (directed[i])
            send_item(directed[i].item, directed[i].fixed, directed[i].want);

        vals = '{32'd4096, 32'd4096, 32'd65535, 32'd8, 32'hFFFF_FFFF};
        write_registers(vals);
        run_random(122);
        vals = '{32'd1, 32'd1, 32'd1, 32'd1, 32'h0};
        write_registers(vals);
        run_random(122);

        send_idle_pct = 64;
        recv_idle_pct = 34;
        // zero-sized window
        vals = '{32'd0, 32'd0, $urandom, $urandom, $urandom};
        write_registers(vals);
        run_random(122);
        vals = '{$urandom, $urandom, $urandom, $urandom, $urandom};
        write_registers(vals);
        run_random(122);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        vals = '{$urandom_range(48, 1), $urandom_range(48, 1), $urandom_range(65535, 1),
                 $urandom_range(8, 1), $urandom};
        write_registers(vals);
        run_random(122);
        vals = '{32'd640, 32'd480, 32'd2560, 32'd4, $urandom};
        write_registers(vals);
        run_random(122);

        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("bresenham_line_stepper_top: match");
        end else begin
            $display("bresenham_line_stepper_top: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("bresenham_line_stepper_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ----- bresenham_line_stepper_top.f -----
design/bls_pkg.sv
design/bresenham_line_stepper_top.sv
tb/tb_bresenham_line_stepper_top.sv
